FILE: hw/rtl/piecewise_linear_color_transfer_lookup_unit_macros.svh
// Assertion macros used by the port-level checker file.
`ifndef PIECEWISE_LINEAR_COLOR_TRANSFER_LOOKUP_UNIT_MACROS_SVH
`define PIECEWISE_LINEAR_COLOR_TRANSFER_LOOKUP_UNIT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define PLCT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define PLCT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

FILE: hw/rtl/plct_pkg.sv
// Package with shared constants and types of the transfer function lookup.
`timescale 1ns / 1ps
package plct_pkg;
    localparam int MaxKeys = 16;
    localparam int IdxW = $clog2(MaxKeys);
    localparam int CntW = $clog2(MaxKeys + 1);
    localparam int PosW = 17;
    localparam int ColW = 32;
    localparam int EntW = PosW + 2 * ColW;
    localparam logic [PosW-1:0] PosOne = 17'h10000;
    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_ADD = 2'd1;
    localparam logic [1:0] CMD_MAP = 2'd2;
    localparam logic [1:0] CMD_IGNORE = 2'd3;
    localparam int InDataW = 104;
    localparam int OutDataW = 40;

    typedef struct packed {
        logic [PosW-1:0] pos;
        logic [ColW-1:0] lcol;
        logic [ColW-1:0] rcol;
    } t_entry;
endpackage

FILE: hw/rtl/plct_key_ram.sv
// Synchronous key table memory, one write and one read port.
`timescale 1ns / 1ps
module plct_key_ram
    import plct_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_we,
    input  logic [IdxW-1:0] i_waddr,
    input  t_entry          i_wdata,
    input  logic [IdxW-1:0] i_raddr,
    output t_entry          o_rdata
);
    t_entry r_mem [MaxKeys];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: hw/rtl/plct_divider.sv
// Serial signed-by-unsigned interpolation divider for one channel product.
`timescale 1ns / 1ps
module plct_divider
    import plct_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [26:0]       i_mag,
    input  logic              i_neg,
    input  logic [PosW-1:0]   i_den,
    output logic              o_done,
    output logic signed [9:0] o_quot
);
    logic [26:0] r_q;
    logic [PosW:0] r_rem;
    logic [4:0] r_cnt;
    logic r_busy;
    logic r_neg;
    logic [PosW-1:0] r_den;
    logic r_done;
    logic [PosW:0] n_trial;
    logic [PosW:0] n_shift;

    always_comb begin
        n_shift = {r_rem[PosW-1:0], r_q[26]};
        n_trial = n_shift - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt <= 5'd0;
                r_q <= i_mag;
                r_rem <= '0;
                r_neg <= i_neg;
                r_den <= i_den;
            end else if (r_busy) begin
                if (!n_trial[PosW]) begin
                    r_rem <= n_trial;
                    r_q <= {r_q[25:0], 1'b1};
                end else begin
                    r_rem <= n_shift;
                    r_q <= {r_q[25:0], 1'b0};
                end
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd26) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? -$signed({1'b0, r_q[8:0]}) : $signed({1'b0, r_q[8:0]});
endmodule

FILE: hw/rtl/piecewise_linear_color_transfer_lookup_unit.sv
// Top level of the piecewise linear RGBA transfer function lookup.
`timescale 1ns / 1ps
// Usage: one request enters on the s_axis group and produces exactly one
// result on the m_axis group. The request carries a command: clear empties
// the key table, add inserts a sorted key, and map turns a sample into an
// interpolated RGBA colour. The keys live in a one-port-read, one-port-write
// synchronous memory; every access goes through a small sequencer.
// Clear goes straight to the output. Add scans the keys one at a time,
// then carries the entries from the insertion point upward by one slot,
// one read and one write per entry. Map scans the keys the same way, then
// runs four channel divisions in turn in a shared bit-serial divider.
// One request is handled at a time; s_axis_tready is high only in idle.
// Reset clears the key count and the sequencer; the memory needs no clearing
// because only entries below the count are ever read.
// When the receiver stalls, the result waits in the output register and the
// next request is not taken until that register has been emptied.
module piecewise_linear_color_transfer_lookup_unit
    import plct_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // key_position[16:0], left r,g,b,a, right r,g,b,a (8 each), sample_value[17:0]
    input  logic [InDataW-1:0]  s_axis_tdata,
    // command[1:0]
    input  logic [1:0]          s_axis_tuser,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // out_red, out_green, out_blue, out_alpha (8 each), keys_held[4:0]
    output logic [OutDataW-1:0] m_axis_tdata,
    // table_full
    output logic                m_axis_tuser
);
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_SCAN = 4'd1;
    localparam logic [3:0] S_SCHK = 4'd2;
    localparam logic [3:0] S_SHFR = 4'd3;
    localparam logic [3:0] S_SHFW = 4'd4;
    localparam logic [3:0] S_MRDL = 4'd5;
    localparam logic [3:0] S_MDIV = 4'd6;
    localparam logic [3:0] S_MWAIT = 4'd7;
    localparam logic [3:0] S_OUT = 4'd8;

    logic [3:0] r_state;
    logic [CntW-1:0] r_count;
    logic [CntW-1:0] r_at;
    logic [1:0] r_cmd;
    t_entry r_new;
    logic [PosW-1:0] r_val;
    t_entry r_right;
    logic [PosW-1:0] r_pl;
    logic [ColW-1:0] r_lc;
    logic [1:0] r_ch;
    logic [ColW-1:0] r_res;
    logic r_full;
    logic r_ovalid;

    logic ram_we;
    logic [IdxW-1:0] ram_waddr;
    t_entry ram_wdata;
    logic [IdxW-1:0] ram_raddr;
    t_entry ram_rdata;

    logic div_start;
    logic [26:0] div_mag;
    logic div_neg;
    logic div_done;
    logic signed [9:0] div_q;
    logic signed [8:0] n_diff;
    logic [16:0] n_dv;
    logic [PosW-1:0] n_pos;
    logic signed [18:0] n_samp;
    logic [7:0] n_a;
    logic [7:0] n_b;
    logic [7:0] n_c;

    plct_key_ram u_ram (
        .i_clk(i_clk), .i_we(ram_we), .i_waddr(ram_waddr), .i_wdata(ram_wdata),
        .i_raddr(ram_raddr), .o_rdata(ram_rdata)
    );

    plct_divider u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start), .i_mag(div_mag),
        .i_neg(div_neg), .i_den(r_right.pos - r_pl), .o_done(div_done), .o_quot(div_q)
    );

    assign s_axis_tready = (r_state == S_IDLE) && !r_ovalid;
    assign m_axis_tvalid = r_ovalid;

    always_comb begin
        n_pos = (s_axis_tdata[16:0] > PosOne) ? PosOne : s_axis_tdata[16:0];
        n_samp = {s_axis_tdata[98], s_axis_tdata[98:81]};
        n_a = r_lc[8*r_ch +: 8];
        n_b = r_right.lcol[8*r_ch +: 8];
        n_diff = $signed({1'b0, n_b}) - $signed({1'b0, n_a});
        n_dv = 17'(r_val - r_pl);
        div_neg = n_diff[8];
        div_mag = 27'(9'(n_diff[8] ? -n_diff : n_diff)) * 27'(n_dv);
        div_start = (r_state == S_MDIV);
        n_c = 8'(10'($signed({2'b0, n_a})) + div_q);
        ram_raddr = IdxW'(r_at);
        ram_we = 1'b0;
        ram_waddr = IdxW'(r_at);
        ram_wdata = r_new;
        // The carried entry goes to the current slot while the old one moves up.
        if (r_state == S_SHFW) begin
            ram_we = 1'b1;
        end
        if (r_state == S_SHFR && r_at == r_count) begin
            ram_we = 1'b1;
        end
        if (r_state == S_SCHK && r_cmd == CMD_ADD &&
            !(r_at < r_count && r_new.pos > ram_rdata.pos)) begin
            ram_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        r_cmd <= s_axis_tuser;
                        r_new <= '{pos: n_pos, lcol: s_axis_tdata[48:17],
                                   rcol: s_axis_tdata[80:49]};
                        r_val <= (n_samp < 0) ? '0 :
                                 (n_samp > 19'sh10000) ? PosOne : PosW'(n_samp);
                        r_at <= '0;
                        r_res <= '0;
                        r_full <= 1'b0;
                        priority if (s_axis_tuser == CMD_CLEAR) begin
                            r_count <= '0;
                            r_state <= S_OUT;
                        end else if (s_axis_tuser == CMD_ADD) begin
                            if (r_count >= CntW'(MaxKeys)) begin
                                r_full <= 1'b1;
                                r_state <= S_OUT;
                            end else begin
                                r_state <= S_SCAN;
                            end
                        end else if (s_axis_tuser == CMD_MAP) begin
                            r_state <= (r_count == '0) ? S_OUT : S_SCAN;
                        end else begin
                            r_state <= S_OUT;
                        end
                    end
                end
                S_SCAN: r_state <= S_SCHK;
                S_SCHK: begin
                    if (r_cmd == CMD_ADD) begin
                        if (r_at < r_count && r_new.pos > ram_rdata.pos) begin
                            r_at <= r_at + CntW'(1);
                            r_state <= S_SCAN;
                        end else if (r_at == r_count) begin
                            r_count <= r_count + CntW'(1);
                            r_state <= S_OUT;
                        end else begin
                            // New key written here; carry the displaced entry up.
                            r_new <= ram_rdata;
                            r_at <= r_at + CntW'(1);
                            r_state <= S_SHFR;
                        end
                    end else begin
                        if (r_val > ram_rdata.pos && r_at < r_count - CntW'(1)) begin
                            r_pl <= ram_rdata.pos;
                            r_lc <= ram_rdata.rcol;
                            r_at <= r_at + CntW'(1);
                            r_state <= S_SCAN;
                        end else if (r_val > ram_rdata.pos) begin
                            r_res <= ram_rdata.rcol;
                            r_state <= S_OUT;
                        end else if (r_at == '0) begin
                            r_res <= ram_rdata.lcol;
                            r_state <= S_OUT;
                        end else begin
                            r_right <= ram_rdata;
                            r_ch <= 2'd0;
                            r_state <= S_MRDL;
                        end
                    end
                end
                S_SHFR: begin
                    // At the old end of the table the carried entry is simply appended.
                    if (r_at == r_count) begin
                        r_count <= r_count + CntW'(1);
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_SHFW;
                    end
                end
                S_SHFW: begin
                    // The entry read at this slot arrives now; carry it to the next one.
                    r_new <= ram_rdata;
                    r_at <= r_at + CntW'(1);
                    r_state <= S_SHFR;
                end
                S_MRDL: r_state <= S_MDIV;
                S_MDIV: r_state <= S_MWAIT;
                S_MWAIT: begin
                    if (div_done) begin
                        r_res[8*r_ch +: 8] <= n_c;
                        r_ch <= r_ch + 2'd1;
                        r_state <= (r_ch == 2'd3) ? S_OUT : S_MDIV;
                    end
                end
                S_OUT: begin
                    if (!r_ovalid) begin
                        r_ovalid <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tdata = {3'b0, r_count, r_res};
    assign m_axis_tuser = r_full;
endmodule

FILE: hw/rtl/plct_checker.sv
// Port-level assertion checker for the transfer function lookup, with bind.
`timescale 1ns / 1ps
`include "piecewise_linear_color_transfer_lookup_unit_macros.svh"
module plct_port_checker
    import plct_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                s_axis_tvalid,
    input logic                s_axis_tready,
    input logic                m_axis_tvalid,
    input logic                m_axis_tready,
    input logic [OutDataW-1:0] m_axis_tdata,
    input logic                m_axis_tuser
)
;
    `PLCT_ASSERT_NXT(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata), "result dropped while stalled")
    `PLCT_ASSERT_IMP(a_busy, i_clk, i_rst_n, m_axis_tvalid, !s_axis_tready,
        "request taken while result pending")
    `PLCT_ASSERT_IMP(a_cnt, i_clk, i_rst_n, m_axis_tvalid,
        m_axis_tdata[36:32] <= 5'(MaxKeys), "key count above capacity")
    `PLCT_ASSERT_IMP(a_full, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser,
        m_axis_tdata[31:0] == 32'd0, "full flag with nonzero colour")
endmodule

bind piecewise_linear_color_transfer_lookup_unit plct_port_checker u_chk (.*);

FILE: sim/plct_checker.sv
// Checker that predicts the transfer function lookup and compares its results.
`timescale 1ns / 1ps
module plct_checker
    import plct_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_req_valid,
    input  logic                i_req_ready,
    input  logic [InDataW-1:0]  i_req_data,
    input  logic [1:0]          i_req_cmd,
    input  logic                i_res_valid,
    input  logic                i_res_ready,
    input  logic [OutDataW-1:0] i_res_data,
    input  logic                i_res_full,
    output int                  o_fail_count,
    output int                  o_pending
);
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic [4:0] held;
        logic       full;
    } t_colour_result;

    logic [PosW-1:0] key_pos[MaxKeys];
    logic [ColW-1:0] key_lcol[MaxKeys];
    logic [ColW-1:0] key_rcol[MaxKeys];
    int              key_total;
    t_colour_result  expected_colours[$];
    int              fails;

    assign o_fail_count = fails;
    assign o_pending = expected_colours.size();

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        fails++;
    endtask

    // Interpolates one colour for a clamped sample, exactly in integers.
    function automatic logic [ColW-1:0] lookup_colour(input logic signed [17:0] sample);
        int unsigned v;
        int at;
        longint a, b, q;
        logic [ColW-1:0] res;
        res = '0;
        if (key_total == 0) return '0;
        if (sample < 0) v = 0;
        else if (sample > 65536) v = 65536;
        else v = sample;
        at = 0;
        while (at < key_total && v > key_pos[at]) at++;
        if (at == 0) return key_lcol[0];
        if (at == key_total) return key_rcol[key_total-1];
        for (int ch = 0; ch < 4; ch++) begin
            a = key_rcol[at-1][8*ch +: 8];
            b = key_lcol[at][8*ch +: 8];
            q = ((b - a) * longint'(v - key_pos[at-1])) / longint'(key_pos[at] - key_pos[at-1]);
            res[8*ch +: 8] = 8'(a + q);
        end
        return res;
    endfunction

    task automatic predict_request(input logic [1:0] cmd, input logic [InDataW-1:0] d);
        t_colour_result r;
        logic [PosW-1:0] p;
        logic [ColW-1:0] c;
        int at;
        r = '0;
        c = '0;
        if (cmd == CMD_CLEAR) begin
            key_total = 0;
        end else if (cmd == CMD_ADD) begin
            p = (d[16:0] > PosOne) ? PosOne : d[16:0];
            if (key_total >= MaxKeys) begin
                r.full = 1'b1;
            end else begin
                at = 0;
                while (at < key_total && p > key_pos[at]) at++;
                for (int i = key_total; i > at; i--) begin
                    key_pos[i] = key_pos[i-1];
                    key_lcol[i] = key_lcol[i-1];
                    key_rcol[i] = key_rcol[i-1];
                end
                key_pos[at] = p;
                key_lcol[at] = d[48:17];
                key_rcol[at] = d[80:49];
                key_total++;
            end
        end else if (cmd == CMD_MAP) begin
            c = lookup_colour(d[81 +: 18]);
        end
        r.red = c[7:0];
        r.green = c[15:8];
        r.blue = c[23:16];
        r.alpha = c[31:24];
        r.held = 5'(key_total);
        expected_colours = {expected_colours, r};
    endtask

    always @(posedge i_clk) begin
        t_colour_result w;
        if (!i_rst_n) begin
            key_total = 0;
        end else begin
            if (i_req_valid && i_req_ready) predict_request(i_req_cmd, i_req_data);
            if (i_res_valid && i_res_ready) begin
                if (expected_colours.size() == 0) begin
                    report_mismatch("unexpected result", 1, 0);
                end else begin
                    w = expected_colours.pop_front();
                    if (i_res_data[7:0] != w.red) report_mismatch("red", i_res_data[7:0], w.red);
                    if (i_res_data[15:8] != w.green)
                        report_mismatch("green", i_res_data[15:8], w.green);
                    if (i_res_data[23:16] != w.blue)
                        report_mismatch("blue", i_res_data[23:16], w.blue);
                    if (i_res_data[31:24] != w.alpha)
                        report_mismatch("alpha", i_res_data[31:24], w.alpha);
                    if (i_res_data[36:32] != w.held)
                        report_mismatch("keys_held", i_res_data[36:32], w.held);
                    if (i_res_full != w.full) report_mismatch("table_full", i_res_full, w.full);
                end
            end
        end
    end

    initial fails = 0;
endmodule

FILE: sim/tb.sv
// Testbench top that drives requests into the transfer function lookup.
`timescale 1ns / 1ps
module tb;
    import plct_pkg::*;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    // key_position[16:0], left r,g,b,a, right r,g,b,a (8 each), sample_value[17:0]
    logic [InDataW-1:0]  s_axis_tdata = '0;
    // command[1:0]
    logic [1:0]          s_axis_tuser = CMD_CLEAR;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    // out_red, out_green, out_blue, out_alpha (8 each), keys_held[4:0]
    logic [OutDataW-1:0] m_axis_tdata;
    // table_full
    logic                m_axis_tuser;
    int                  fail_count;
    int                  pending;
    int                  send_idle_pct;
    int                  recv_idle_pct;

    always #10 i_clk = ~i_clk;

    piecewise_linear_color_transfer_lookup_unit u_top (.*);

    plct_checker u_check (
        .i_clk, .i_rst_n,
        .i_req_valid(s_axis_tvalid), .i_req_ready(s_axis_tready),
        .i_req_data(s_axis_tdata), .i_req_cmd(s_axis_tuser),
        .i_res_valid(m_axis_tvalid), .i_res_ready(m_axis_tready),
        .i_res_data(m_axis_tdata), .i_res_full(m_axis_tuser),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // The receiver stalls at random with the chance of the current phase.
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Drives one request and holds it until the block takes it; the sender
    // may insert idle cycles before presenting it.
    task automatic send_request(input logic [1:0] cmd, input logic [16:0] pos,
                                input logic [31:0] lcol, input logic [31:0] rcol,
                                input logic [17:0] sample);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= cmd;
        s_axis_tdata <= {5'd0, sample, rcol, lcol, pos};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    function automatic logic [16:0] pick_position();
        case ($urandom_range(5))
            0: return 17'd0;
            1: return PosOne;
            2: return 17'($urandom_range(131071));
            default: return 17'($urandom_range(65536));
        endcase
    endfunction

    function automatic logic [17:0] pick_sample();
        case ($urandom_range(5))
            0: return 18'($urandom);
            1: return 18'd0;
            2: return 18'h10000;
            default: return 18'($urandom_range(65536));
        endcase
    endfunction

    // Mostly builds tables and maps samples through them; clears and
    // ignored commands are rarer so tables often fill.
    task automatic random_phase(input int count);
        int r;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(99);
            if (r < 3) send_request(CMD_CLEAR, 17'($urandom), $urandom, $urandom, 18'($urandom));
            else if (r < 5) send_request(CMD_IGNORE, 17'($urandom), $urandom, $urandom,
                                         18'($urandom));
            else if (r < 35) send_request(CMD_ADD, pick_position(), $urandom, $urandom,
                                          18'($urandom));
            else send_request(CMD_MAP, 17'($urandom), $urandom, $urandom, pick_sample());
        end
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty map, extremes of samples, duplicate positions,
        // key above one, overfill, ignored command and clear.
        send_request(CMD_MAP, 17'd0, 0, 0, 18'h10000);
        send_request(CMD_ADD, 17'h1FFFF, 32'hFFFFFFFF, 32'h00000000, 18'h3FFFF);
        send_request(CMD_ADD, 17'd0, 32'h00000000, 32'hFFFFFFFF, 18'd0);
        send_request(CMD_ADD, 17'h08000, 32'h80FF0011, 32'h12345678, 18'd0);
        send_request(CMD_ADD, 17'h08000, 32'h01020304, 32'hA5A55A5A, 18'd0);
        send_request(CMD_MAP, 17'd0, 0, 0, 18'h20000);
        send_request(CMD_MAP, 17'd0, 0, 0, 18'h1FFFF);
        send_request(CMD_MAP, 17'd0, 0, 0, 18'h00001);
        send_request(CMD_MAP, 17'd0, 0, 0, 18'h08000);
        send_request(CMD_MAP, 17'd0, 0, 0, 18'h0C001);
        send_request(CMD_MAP, 17'd0, 0, 0, 18'h03FFF);
        send_request(CMD_IGNORE, 17'h1FFFF, '1, '1, 18'h3FFFF);
        for (int i = 0; i < 13; i++)
            send_request(CMD_ADD, 17'(i * 5000 + 1), $urandom, $urandom, 18'd0);
        send_request(CMD_MAP, 17'd0, 0, 0, 18'h0ABCD);
        send_request(CMD_CLEAR, 17'h1FFFF, '1, '1, 18'h3FFFF);
        send_request(CMD_ADD, 17'h00100, 32'h11223344, 32'h55667788, 18'd0);
        send_request(CMD_MAP, 17'd0, 0, 0, 18'h00200);
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);

        send_idle_pct = 26;
        recv_idle_pct = 75;
        random_phase(580);
        send_idle_pct = 75;
        recv_idle_pct = 26;
        random_phase(580);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        random_phase(590);

        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // Worst case is about 1800 requests with long stalls.
    initial begin
        #40ms;
        $display("Test completed with failures");
        $finish;
    end
endmodule

FILE: piecewise_linear_color_transfer_lookup_unit.f
+incdir+hw/rtl
hw/rtl/plct_pkg.sv
hw/rtl/plct_key_ram.sv
hw/rtl/plct_divider.sv
hw/rtl/piecewise_linear_color_transfer_lookup_unit.sv
hw/rtl/plct_checker.sv
sim/plct_checker.sv
sim/tb.sv
